/* rtl/core/r2q_pkg.sv */
// ============================================================================
// r2q_pkg - shared types and constants for the rotation to quaternion block
// Widths of the branch values, the divider and the square root lanes.
// ============================================================================
`default_nettype none

package r2q_pkg;

   localparam int ONE_Q14   = 16384;
   localparam int IN_W      = 16;
   localparam int OUT_W     = 16;
   localparam int LANES     = 4;             // x, y, z, w
   localparam int VAL_W     = 18;            // signed branch values
   localparam int MAG_W     = 17;            // magnitude of a branch value
   localparam int SQ_W      = 2 * MAG_W;     // square of a magnitude
   localparam int SUM_W     = SQ_W + 3;      // sum of four squares
   localparam int REM_W     = SUM_W + 1;     // divider partial remainder
   localparam int QUO_W     = 32;            // quotient bits, one extra LSB
   localparam int DIV_STEPS = QUO_W / 2;     // two quotient bits a cycle
   localparam int RAD_W     = QUO_W - 1;     // square root operand
   localparam int ROOT_W    = 16;
   localparam int SQR_REM_W = ROOT_W + 3;
   localparam int SQR_STEPS = ROOT_W;
   localparam int QUEUE_DEPTH_DEF = 2;

   typedef enum logic [3:0] {
      BR_W = 4'b0001,
      BR_X = 4'b0010,
      BR_Y = 4'b0100,
      BR_Z = 4'b1000
   } branch_type;

   // classified item: squared magnitudes, their sum and the signs
   typedef struct packed {
      logic [LANES-1:0][SQ_W-1:0] sq;
      logic [SUM_W-1:0]           sum;
      logic [LANES-1:0]           neg;
      logic                       ok;
   } work_type;

   // quotients handed from the divider to the square root unit
   typedef struct packed {
      logic [LANES-1:0][RAD_W-1:0] rad;
      logic [LANES-1:0]            neg;
      logic                        ok;
   } rad_type;

endpackage

`default_nettype wire

/* rtl/core/r2q_ifs.sv */
// ============================================================================
// r2q_ifs - channel interfaces of the rotation to quaternion block
// Matrix request channel and quaternion response channel, valid/ready.
// ============================================================================
`default_nettype none

interface r2q_req_if import r2q_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [IN_W-1:0]  rot_00;
   logic signed [IN_W-1:0]  rot_01;
   logic signed [IN_W-1:0]  rot_02;
   logic signed [IN_W-1:0]  rot_10;
   logic signed [IN_W-1:0]  rot_11;
   logic signed [IN_W-1:0]  rot_12;
   logic signed [IN_W-1:0]  rot_20;
   logic signed [IN_W-1:0]  rot_21;
   logic signed [IN_W-1:0]  rot_22;

   modport source (
      output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
             rot_20, rot_21, rot_22,
      input  ready
   );
   modport sink (
      input  valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
             rot_20, rot_21, rot_22,
      output ready
   );
endinterface

interface r2q_rsp_if import r2q_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] quat_x;
   logic signed [OUT_W-1:0] quat_y;
   logic signed [OUT_W-1:0] quat_z;
   logic signed [OUT_W-1:0] quat_w;
   logic                    valid_res;

   modport source (
      output valid, quat_x, quat_y, quat_z, quat_w, valid_res,
      input  ready
   );
   modport sink (
      input  valid, quat_x, quat_y, quat_z, quat_w, valid_res,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/rotation_to_quaternion.sv */
// ============================================================================
// rotation_to_quaternion - 3x3 rotation matrix to unit quaternion
// Top level: front classifier, transaction queue, divider, square root.
// ============================================================================
// Each request transaction carries nine signed Q1.14 matrix entries and
// yields exactly one response: a unit quaternion (x, y, z, w) in signed
// Q1.14 and valid_res. The trace branch is taken when the trace is positive,
// otherwise the branch of the largest diagonal entry. Each component is
// rounded to nearest (ties away from zero) as 16384*v/sqrt(sum of v^2). When
// the branch radicand is zero or negative, valid_res is low and the response
// is the identity (0, 0, 0, 1.0). While the response side keeps ready high,
// the rate at which matrices are taken is set by the divider, which
// resolves two quotient bits a cycle, and by the square root unit, which
// resolves one root bit a cycle; the two overlap on successive transactions,
// but neither takes a new one while still iterating on the last. A request
// passes three front stages, the queue, the divider and the square root on
// its way to the response. Requests keep being accepted into the front pipe
// and queue while a finished response waits to be taken, until both fill.
// ============================================================================
`default_nettype none

module rotation_to_quaternion import r2q_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   r2q_req_if.sink    req_bus,
   r2q_rsp_if.source  rsp_bus
);

   // front -> queue
   work_type front_data;
   logic     front_valid;
   logic     front_ready;

   // queue -> divider
   work_type queue_data;
   logic     queue_valid;
   logic     queue_ready;

   // divider -> square root
   rad_type  div_data;
   logic     div_valid;
   logic     div_ready;

   // classify and square; stall the pipe when the queue fills
   r2q_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .work_data  (front_data),
      .work_valid (front_valid),
      .work_ready (front_ready)
   );

   // decouple the front from the iterative back end
   r2q_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_data   (front_data),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_data  (queue_data),
      .out_valid (queue_valid),
      .out_ready (queue_ready)
   );

   // hold the quotient until the square root unit takes it
   r2q_div u_div (
      .clock      (clock),
      .reset      (reset),
      .work_data  (queue_data),
      .work_valid (queue_valid),
      .work_ready (queue_ready),
      .rad_data   (div_data),
      .rad_valid  (div_valid),
      .rad_ready  (div_ready)
   );

   // root, round, clamp and drive the response register
   r2q_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .rad_data  (div_data),
      .rad_valid (div_valid),
      .rad_ready (div_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

/* rtl/core/r2q_front.sv */
// ============================================================================
// r2q_front - branch selection and squared norm
// Picks the trace or largest diagonal branch, forms the four scaled components,
// squares them and sums the squares over three pipeline stages.
// ============================================================================
`default_nettype none

module r2q_front import r2q_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   r2q_req_if.sink  req_bus,
   output work_type work_data,
   output logic     work_valid,
   input  logic     work_ready
);

   localparam logic signed [VAL_W-1:0] ONE_V = VAL_W'(ONE_Q14);

   logic signed [VAL_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [VAL_W-1:0] trace;
   logic signed [VAL_W-1:0] rad;
   logic signed [VAL_W-1:0] v [LANES];
   logic [VAL_W-1:0]        absv [LANES];
   branch_type              branch;
   logic                    adv;

   logic                    a_valid_ff, a_valid_in;
   logic [MAG_W-1:0]        a_mag_ff [LANES];
   logic [MAG_W-1:0]        a_mag_in [LANES];
   logic [LANES-1:0]        a_neg_ff, a_neg_in;
   logic                    a_ok_ff, a_ok_in;

   logic                    b_valid_ff, b_valid_in;
   logic [SQ_W-1:0]         b_sq_ff [LANES];
   logic [SQ_W-1:0]         b_sq_in [LANES];
   logic [LANES-1:0]        b_neg_ff, b_neg_in;
   logic                    b_ok_ff, b_ok_in;

   logic                    c_valid_ff, c_valid_in;
   work_type                c_work_ff, c_work_in;

   // the whole pipe moves as one while the last stage can drain
   assign adv           = !c_valid_ff || work_ready;
   assign req_bus.ready = adv;

   always_comb begin
      e00 = VAL_W'(req_bus.rot_00);
      e01 = VAL_W'(req_bus.rot_01);
      e02 = VAL_W'(req_bus.rot_02);
      e10 = VAL_W'(req_bus.rot_10);
      e11 = VAL_W'(req_bus.rot_11);
      e12 = VAL_W'(req_bus.rot_12);
      e20 = VAL_W'(req_bus.rot_20);
      e21 = VAL_W'(req_bus.rot_21);
      e22 = VAL_W'(req_bus.rot_22);
      trace = e00 + e11 + e22;

      if (trace > 0) begin
         branch = BR_W;
      end else if (e00 > e11 && e00 > e22) begin
         branch = BR_X;
      end else if (e11 > e22) begin
         branch = BR_Y;
      end else begin
         branch = BR_Z;
      end

      case (branch)
         BR_W: begin
            rad  = ONE_V + trace;
            v[0] = e21 - e12;
            v[1] = e02 - e20;
            v[2] = e10 - e01;
            v[3] = rad;
         end
         BR_X: begin
            rad  = ONE_V + e00 - e11 - e22;
            v[0] = rad;
            v[1] = e01 + e10;
            v[2] = e02 + e20;
            v[3] = e21 - e12;
         end
         BR_Y: begin
            rad  = ONE_V + e11 - e00 - e22;
            v[0] = e01 + e10;
            v[1] = rad;
            v[2] = e12 + e21;
            v[3] = e02 - e20;
         end
         default: begin
            rad  = ONE_V + e22 - e00 - e11;
            v[0] = e02 + e20;
            v[1] = e12 + e21;
            v[2] = rad;
            v[3] = e10 - e01;
         end
      endcase

      a_valid_in = req_bus.valid;
      a_ok_in    = rad > 0;
      for (int i = 0; i < LANES; i++) begin
         absv[i]     = v[i][VAL_W-1] ? VAL_W'(-v[i]) : VAL_W'(v[i]);
         a_mag_in[i] = absv[i][MAG_W-1:0];
         a_neg_in[i] = v[i][VAL_W-1];
      end

      b_valid_in = a_valid_ff;
      b_neg_in   = a_neg_ff;
      b_ok_in    = a_ok_ff;
      for (int i = 0; i < LANES; i++) begin
         b_sq_in[i] = SQ_W'(a_mag_ff[i]) * SQ_W'(a_mag_ff[i]);
      end

      c_valid_in    = b_valid_ff;
      c_work_in.neg = b_neg_ff;
      c_work_in.ok  = b_ok_ff;
      c_work_in.sum = SUM_W'(b_sq_ff[0]) + SUM_W'(b_sq_ff[1])
                    + SUM_W'(b_sq_ff[2]) + SUM_W'(b_sq_ff[3]);
      for (int i = 0; i < LANES; i++) begin
         c_work_in.sq[i] = b_sq_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         a_ok_ff   <= a_ok_in;
         b_sq_ff   <= b_sq_in;
         b_neg_ff  <= b_neg_in;
         b_ok_ff   <= b_ok_in;
         c_work_ff <= c_work_in;
      end
   end

   assign work_data  = c_work_ff;
   assign work_valid = c_valid_ff;

endmodule

`default_nettype wire

/* rtl/core/r2q_queue.sv */
// ============================================================================
// r2q_queue - short queue between front and back
// Holds classified transactions so either side may stall on its own.
// ============================================================================
`default_nettype none

module r2q_queue import r2q_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  work_type in_data,
   input  logic     in_valid,
   output logic     in_ready,
   output work_type out_data,
   output logic     out_valid,
   input  logic     out_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   work_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue fill count beyond depth");
`endif

endmodule

`default_nettype wire

/* rtl/core/r2q_div.sv */
// ============================================================================
// r2q_div - four lane restoring divider
// Divides each squared magnitude, scaled by 2^31, by the sum of squares,
// two quotient bits a cycle.
// ============================================================================
`default_nettype none

module r2q_div import r2q_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  work_type work_data,
   input  logic     work_valid,
   output logic     work_ready,
   output rad_type  rad_data,
   output logic     rad_valid,
   input  logic     rad_ready
);

   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [REM_W-1:0]  rem_ff [LANES];
   logic [REM_W-1:0]  rem_in [LANES];
   logic [QUO_W-1:0]  quo_ff [LANES];
   logic [QUO_W-1:0]  quo_in [LANES];
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [LANES-1:0]  neg_ff, neg_in;
   logic              ok_ff, ok_in;
   logic [REM_W:0]    s1 [LANES];
   logic [REM_W:0]    s2 [LANES];
   logic              take;

   // one compare-subtract, then shift; MSB of the result is the quotient bit
   function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic [SUM_W-1:0] den);
      logic [REM_W-1:0] dext;
      logic [REM_W-1:0] diff;
      logic             ge;
      dext = REM_W'(den);
      ge   = rem >= dext;
      diff = ge ? rem - dext : rem;
      return {ge, diff[REM_W-2:0], 1'b0};
   endfunction

   assign work_ready = !busy_ff && (!done_ff || rad_ready);
   assign take       = work_valid && work_ready;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      ok_in   = ok_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      for (int i = 0; i < LANES; i++) begin
         s1[i] = div_step(rem_ff[i], den_ff);
         s2[i] = div_step(s1[i][REM_W-1:0], den_ff);
      end

      if (done_ff && rad_ready) begin
         done_in = 1'b0;
      end
      if (take) begin
         busy_in = 1'b1;
         step_in = '0;
         den_in  = work_data.sum;
         neg_in  = work_data.neg;
         ok_in   = work_data.ok;
         for (int i = 0; i < LANES; i++) begin
            rem_in[i] = REM_W'(work_data.sq[i]);
            quo_in[i] = '0;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < LANES; i++) begin
            rem_in[i] = s2[i][REM_W-1:0];
            quo_in[i] = {quo_ff[i][QUO_W-3:0], s1[i][REM_W], s2[i][REM_W]};
         end
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      ok_ff  <= ok_in;
   end

   always_comb begin
      rad_data.neg = neg_ff;
      rad_data.ok  = ok_ff;
      for (int i = 0; i < LANES; i++) begin
         // drop the extra quotient bit: floor of half keeps the floor
         rad_data.rad[i] = quo_ff[i][QUO_W-1:1];
      end
   end
   assign rad_valid = done_ff;

`ifndef ASSERT_OFF
   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy while holding a result");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == LAST_STEP) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after its last step");
`endif

endmodule

`default_nettype wire

/* rtl/core/r2q_sqrt.sv */
// ============================================================================
// r2q_sqrt - four lane square root, rounding and response register
// Integer square root one result bit a cycle, then halve with rounding,
// clamp to one and restore the sign, or give the identity for a failed item.
// ============================================================================
`default_nettype none

module r2q_sqrt import r2q_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  rad_type    rad_data,
   input  logic       rad_valid,
   output logic       rad_ready,
   r2q_rsp_if.source  rsp_bus
);

   localparam int STEP_W = $clog2(SQR_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SQR_STEPS - 1);
   localparam logic [ROOT_W-1:0] ONE_MAG   = ROOT_W'(ONE_Q14);
   localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(ONE_Q14);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [SQR_REM_W-1:0]    rem_ff [LANES];
   logic [SQR_REM_W-1:0]    rem_in [LANES];
   logic [ROOT_W-1:0]       root_ff [LANES];
   logic [ROOT_W-1:0]       root_in [LANES];
   logic [QUO_W-1:0]        opd_ff [LANES];
   logic [QUO_W-1:0]        opd_in [LANES];
   logic [LANES-1:0]        neg_ff, neg_in;
   logic                    ok_ff, ok_in;
   logic signed [OUT_W-1:0] quat_ff [LANES];
   logic signed [OUT_W-1:0] quat_in [LANES];
   logic                    res_ok_ff, res_ok_in;

   logic [SQR_REM_W-1:0]    cur [LANES];
   logic [SQR_REM_W-1:0]    trial [LANES];
   logic                    ge [LANES];
   logic [ROOT_W-1:0]       root_nx [LANES];
   logic [ROOT_W:0]         plus1 [LANES];
   logic [ROOT_W-1:0]       mag [LANES];
   logic                    take;

   assign rad_ready = !busy_ff && (!done_ff || rsp_bus.ready);
   assign take      = rad_valid && rad_ready;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = done_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      opd_in    = opd_ff;
      neg_in    = neg_ff;
      ok_in     = ok_ff;
      quat_in   = quat_ff;
      res_ok_in = res_ok_ff;

      for (int i = 0; i < LANES; i++) begin
         cur[i]     = {rem_ff[i][SQR_REM_W-3:0], opd_ff[i][QUO_W-1:QUO_W-2]};
         trial[i]   = {1'b0, root_ff[i], 2'b01};
         ge[i]      = cur[i] >= trial[i];
         root_nx[i] = {root_ff[i][ROOT_W-2:0], ge[i]};
         // round half away from zero: (root + 1) / 2, then clamp
         plus1[i]   = {1'b0, root_nx[i]} + (ROOT_W+1)'(1);
         mag[i]     = (plus1[i][ROOT_W:1] > ONE_MAG) ? ONE_MAG : plus1[i][ROOT_W:1];
      end

      if (done_ff && rsp_bus.ready) begin
         done_in = 1'b0;
      end
      if (take) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = rad_data.neg;
         ok_in   = rad_data.ok;
         for (int i = 0; i < LANES; i++) begin
            rem_in[i]  = '0;
            root_in[i] = '0;
            opd_in[i]  = QUO_W'(rad_data.rad[i]);
         end
      end else if (busy_ff) begin
         for (int i = 0; i < LANES; i++) begin
            rem_in[i]  = ge[i] ? cur[i] - trial[i] : cur[i];
            root_in[i] = root_nx[i];
            opd_in[i]  = {opd_ff[i][QUO_W-3:0], 2'b00};
         end
         if (step_ff == LAST_STEP) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            res_ok_in = ok_ff;
            for (int i = 0; i < LANES; i++) begin
               if (!ok_ff) begin
                  quat_in[i] = (i == LANES - 1) ? ONE_OUT : '0;
               end else if (neg_ff[i]) begin
                  quat_in[i] = OUT_W'(-mag[i]);
               end else begin
                  quat_in[i] = OUT_W'(mag[i]);
               end
            end
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      opd_ff    <= opd_in;
      neg_ff    <= neg_in;
      ok_ff     <= ok_in;
      quat_ff   <= quat_in;
      res_ok_ff <= res_ok_in;
   end

   assign rsp_bus.valid     = done_ff;
   assign rsp_bus.quat_x    = quat_ff[0];
   assign rsp_bus.quat_y    = quat_ff[1];
   assign rsp_bus.quat_z    = quat_ff[2];
   assign rsp_bus.quat_w    = quat_ff[3];
   assign rsp_bus.valid_res = res_ok_ff;

`ifndef ASSERT_OFF
   a_fail_identity: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !res_ok_ff) |-> (quat_ff[3] == ONE_OUT && quat_ff[0] == '0))
      else $error("failed conversion not reported as identity");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !rad_ready)
      else $error("square root unit ready while iterating");
`endif

endmodule

`default_nettype wire
